FILE: src/pmtuc_pkg.sv
// Shared types and constants for the path MTU cache.
package pmtuc_pkg;

  localparam int ADDR_W = 64;
  localparam int MTU_W  = 32;
  localparam int TICK_W = 16;

  // Lifetime register: writes at or below the floor are ignored.
  localparam logic [TICK_W-1:0] MIN_VALIDITY     = TICK_W'(60 * 5);
  localparam logic [TICK_W-1:0] DEFAULT_VALIDITY = TICK_W'(60 * 10);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_SET    = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

endpackage

FILE: src/pmtuc_req_if.sv
// Request channel: opcode, destination address and MTU to store.
interface pmtuc_req_if
  import pmtuc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ADDR_W-1:0] addr_hi;
  logic [ADDR_W-1:0] addr_lo;
  logic [MTU_W-1:0]  new_mtu;

  modport source (output valid, output opcode, output addr_hi, output addr_lo,
                  output new_mtu, input ready);
  modport sink   (input valid, input opcode, input addr_hi, input addr_lo,
                  input new_mtu, output ready);
endinterface

FILE: src/pmtuc_rsp_if.sv
// Response channel: looked-up MTU and hit / stored flags.
interface pmtuc_rsp_if
  import pmtuc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MTU_W-1:0] mtu_value;
  logic             found;
  logic             stored;

  modport source (output valid, output mtu_value, output found, output stored,
                  input ready);
  modport sink   (input valid, input mtu_value, input found, input stored,
                  output ready);
endinterface

FILE: src/pmtuc_cfg_if.sv
// Configuration write channel for the entry lifetime register.
interface pmtuc_cfg_if
  import pmtuc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/path_mtu_cache_with_expiry_unit.sv
// Fully associative IPv6 path MTU cache with per-entry expiry countdown.
//
// Takes one request per cycle. The request is registered into s1 at its
// transfer; in the next cycle its address is compared against every entry in
// parallel, and the response is registered into the output register when s1
// fires; the whole table is searched, updated or aged in that compare stage.
// A response held by the sink stalls the lookup or set behind it; ticks and
// opcode 3 never wait on the response side. Lookups and sets give one
// response each, ticks and opcode 3 give none. A set that misses with every
// entry live is dropped and answered with stored = 0. Lifetime writes of
// 300 or less are ignored; the register resets to 600.
module path_mtu_cache_with_expiry_unit
  import pmtuc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  pmtuc_cfg_if.sink   cfg,
  pmtuc_req_if.sink   req,
  pmtuc_rsp_if.source rsp
);

  logic [TICK_W-1:0] validity_ticks;

  logic [ENTRIES-1:0] entry_live;
  logic [ADDR_W-1:0]  entry_addr_upper [ENTRIES];
  logic [ADDR_W-1:0]  entry_addr_lower [ENTRIES];
  logic [MTU_W-1:0]   entry_mtu        [ENTRIES];
  logic [TICK_W-1:0]  entry_remaining  [ENTRIES];

  logic              s1_valid;
  logic [1:0]        s1_op;
  logic [ADDR_W-1:0] s1_addr_hi;
  logic [ADDR_W-1:0] s1_addr_lo;
  logic [MTU_W-1:0]  s1_mtu;

  logic             out_valid;
  logic [MTU_W-1:0] out_mtu;
  logic             out_found;
  logic             out_stored;

  logic               is_lookup;
  logic               is_set;
  logic               is_tick;
  logic               s1_fire;
  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] free_neg;
  logic [ENTRIES-1:0] free_low;
  logic [ENTRIES-1:0] target;
  logic [MTU_W-1:0]   hit_mtu;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      validity_ticks <= DEFAULT_VALIDITY;
    end else if (cfg.valid && (cfg.data > MIN_VALIDITY)) begin
      validity_ticks <= cfg.data;
    end
  end

  // ---------------------------------------------------------------- control
  assign is_lookup = (s1_op == OP_LOOKUP);
  assign is_set    = (s1_op == OP_SET);
  assign is_tick   = (s1_op == OP_TICK);

  // ticks and unused opcodes never wait on the response side
  assign s1_fire   = s1_valid && (!(is_lookup || is_set) || !out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op      <= req.opcode;
      s1_addr_hi <= req.addr_hi;
      s1_addr_lo <= req.addr_lo;
      s1_mtu     <= req.new_mtu;
    end
  end

  // ---------------------------------------------------------------- search
  always_comb begin
    hit_mtu = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = entry_live[i] && (entry_addr_upper[i] == s1_addr_hi) &&
               (entry_addr_lower[i] == s1_addr_lo);
      hit_mtu = hit_mtu | (hit[i] ? entry_mtu[i] : '0);
    end
  end

  // lowest free entry as a one-hot: x & -x
  assign free     = ~entry_live;
  assign free_neg = ~free + ENTRIES'(1);
  assign free_low = free & free_neg;
  assign target   = (|hit) ? hit : free_low;

  // ---------------------------------------------------------------- table
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_live <= '0;
    end else if (s1_fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (is_set && target[i]) begin
          entry_live[i] <= 1'b1;
        end else if (is_tick && entry_live[i] && (entry_remaining[i] <= TICK_W'(1))) begin
          entry_live[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (is_set && target[i]) begin
          entry_addr_upper[i] <= s1_addr_hi;
          entry_addr_lower[i] <= s1_addr_lo;
          entry_mtu[i]        <= s1_mtu;
          entry_remaining[i]  <= validity_ticks;
        end else if (is_tick && entry_live[i]) begin
          if (entry_remaining[i] <= TICK_W'(1)) begin
            entry_remaining[i] <= '0;
          end else begin
            entry_remaining[i] <= entry_remaining[i] - TICK_W'(1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && (is_lookup || is_set)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (is_lookup || is_set)) begin
      out_mtu    <= is_lookup ? hit_mtu : '0;
      out_found  <= is_lookup && (|hit);
      out_stored <= is_set && (|target);
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.mtu_value = out_mtu;
  assign rsp.found     = out_found;
  assign rsp.stored    = out_stored;

`ifndef SYNTHESIS
  // a set must never create a second live copy of an address
  assert property (@(posedge clk) disable iff (rst) s1_valid |-> $onehot0(hit))
    else $error("multiple live entries match one address");

  assert property (@(posedge clk) disable iff (rst) validity_ticks > MIN_VALIDITY)
    else $error("lifetime register at or below floor");

  assert property (@(posedge clk) disable iff (rst) rsp.valid |-> !(rsp.found && rsp.stored))
    else $error("response flags both hit and stored");

  // a set that found a free or matching entry must mark it live
  assert property (@(posedge clk) disable iff (rst)
                   (s1_fire && is_set && (|target)) |=> ((entry_live & $past(target)) != '0))
    else $error("stored set left its entry free");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the IPv6 path MTU cache with entry expiry.
module testbench;
  import pmtuc_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int POOL        = 24;
  localparam int DRAIN_WAIT  = 6;
  localparam int HOLD_CYCLES = 200;
  localparam int LIMIT_NS    = 5_000_000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic [MTU_W-1:0]  mtu;
  } cache_req_t;

  typedef struct packed {
    logic [MTU_W-1:0] mtu_value;
    logic             found;
    logic             stored;
  } cache_rsp_t;

  typedef struct {
    cache_req_t item;
    bit         typed;
    cache_rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  pmtuc_cfg_if cfg_bus ();
  pmtuc_req_if req_bus ();
  pmtuc_rsp_if rsp_bus ();

  path_mtu_cache_with_expiry_unit #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // Cache image kept alongside the block
  logic              slot_live [ENTRIES];
  logic [ADDR_W-1:0] slot_hi   [ENTRIES];
  logic [ADDR_W-1:0] slot_lo   [ENTRIES];
  logic [MTU_W-1:0]  slot_mtu  [ENTRIES];
  logic [TICK_W-1:0] slot_ttl  [ENTRIES];
  logic [TICK_W-1:0] lifetime;

  cache_rsp_t        pending_rsp_q [$];
  dir_row_t          dir_rows [$];
  logic [ADDR_W-1:0] pool_hi [POOL];
  logic [ADDR_W-1:0] pool_lo [POOL];

  // Side band for hand-typed expectations, driven along with each request
  bit         item_typed;
  cache_rsp_t item_want;

  bit src_idle_on;
  bit sink_idle_on;
  bit rsp_hold_pending;

  int mismatch_count;
  int request_count;
  int hit_count;
  int miss_count;
  int stored_count;
  int dropped_count;
  int expired_count;
  int lifetime_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit predict_cache_response(input cache_req_t r, output cache_rsp_t rsp);
    int i;
    int slot;
    bit has_rsp;
    rsp = '0;
    slot = -1;
    has_rsp = 1'b0;
    case (r.op)
      OP_LOOKUP: begin
        for (i = 0; i < ENTRIES; i++)
          if (slot < 0 && slot_live[i] && slot_hi[i] == r.hi && slot_lo[i] == r.lo) slot = i;
        if (slot >= 0) begin
          rsp.mtu_value = slot_mtu[slot];
          rsp.found = 1'b1;
        end
        has_rsp = 1'b1;
      end
      OP_SET: begin
        for (i = 0; i < ENTRIES; i++)
          if (slot < 0 && slot_live[i] && slot_hi[i] == r.hi && slot_lo[i] == r.lo) slot = i;
        for (i = 0; i < ENTRIES; i++)
          if (slot < 0 && !slot_live[i]) slot = i;
        // miss with every slot live: dropped
        if (slot >= 0) begin
          slot_live[slot] = 1'b1;
          slot_hi[slot] = r.hi;
          slot_lo[slot] = r.lo;
          slot_mtu[slot] = r.mtu;
          slot_ttl[slot] = lifetime;
          rsp.stored = 1'b1;
        end
        has_rsp = 1'b1;
      end
      OP_TICK: begin
        for (i = 0; i < ENTRIES; i++) begin
          if (slot_live[i]) begin
            if (slot_ttl[i] <= 1) begin
              slot_ttl[i] = '0;
              slot_live[i] = 1'b0;
              expired_count++;
            end else begin
              slot_ttl[i] = slot_ttl[i] - 1'b1;
            end
          end
        end
      end
      default: has_rsp = 1'b0;
    endcase
    return has_rsp;
  endfunction

  // Transfer monitor: checks responses, tracks lifetime writes, predicts requests
  always @(posedge clk) begin : monitor
    cache_req_t acc;
    cache_rsp_t got;
    cache_rsp_t want;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got = '{mtu_value: rsp_bus.mtu_value, found: rsp_bus.found, stored: rsp_bus.stored};
        if (pending_rsp_q.size() == 0) begin
          $error("unexpected response: mtu_value %0h found %0b stored %0b",
                 got.mtu_value, got.found, got.stored);
          mismatch_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (got.mtu_value !== want.mtu_value) begin
            $error("mtu_value: expected %0h, got %0h", want.mtu_value, got.mtu_value);
            mismatch_count++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, got.found);
            mismatch_count++;
          end
          if (got.stored !== want.stored) begin
            $error("stored: expected %0b, got %0b", want.stored, got.stored);
            mismatch_count++;
          end
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        lifetime_writes++;
        if (cfg_bus.data > MIN_VALIDITY) lifetime = cfg_bus.data;
      end
      if (req_bus.valid && req_bus.ready) begin
        acc = '{op: req_bus.opcode, hi: req_bus.addr_hi, lo: req_bus.addr_lo,
                mtu: req_bus.new_mtu};
        request_count++;
        if (predict_cache_response(acc, want)) begin
          if (acc.op == OP_LOOKUP) begin
            if (want.found) hit_count++;
            else miss_count++;
          end else if (want.stored) begin
            stored_count++;
          end else begin
            dropped_count++;
          end
          pending_rsp_q.push_back(item_typed ? item_want : want);
        end
      end
    end
  end

  // Response sink: random stall per transfer, plus one long hold when asked
  initial begin : response_sink
    int stall;
    rsp_bus.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rsp_hold_pending) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rsp_hold_pending = 1'b0;
      end
      stall = sink_idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      @(negedge clk);
    end
  end

  // Returns at the rising edge of the transfer; valid stays up for a back-to-back item
  task automatic send_req(input cache_req_t item, input bit typed, input cache_rsp_t want);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid   <= 1'b1;
    req_bus.opcode  <= item.op;
    req_bus.addr_hi <= item.hi;
    req_bus.addr_lo <= item.lo;
    req_bus.new_mtu <= item.mtu;
    item_typed      <= typed;
    item_want       <= want;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk);
    // ticks give no response and may still be in flight
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_lifetime(input logic [TICK_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic cache_req_t pool_request(input logic [1:0] op);
    cache_req_t item;
    int p;
    p = $urandom_range(0, POOL - 1);
    item.op  = op;
    item.hi  = pool_hi[p];
    item.lo  = pool_lo[p];
    item.mtu = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      item.hi = {$urandom, $urandom};
      item.lo = {$urandom, $urandom};
    end
    return item;
  endfunction

  function automatic cache_req_t random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return pool_request(OP_LOOKUP);
    if (r < 75) return pool_request(OP_SET);
    if (r < 92) return pool_request(OP_TICK);
    return pool_request(OP_UNUSED);
  endfunction

  task automatic run_random(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        src_idle_on  = $urandom_range(0, 3) != 0;
        sink_idle_on = $urandom_range(0, 3) != 0;
      end
      send_req(random_request(), 1'b0, '0);
    end
  endtask

  function automatic void add_row(input logic [1:0] op, input logic [ADDR_W-1:0] hi,
                                  input logic [ADDR_W-1:0] lo, input logic [MTU_W-1:0] mtu,
                                  input bit typed, input cache_rsp_t want);
    dir_row_t row;
    row.item  = '{op: op, hi: hi, lo: lo, mtu: mtu};
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  initial begin : stimulus
    localparam logic [ADDR_W-1:0] ONES = '1;
    localparam logic [ADDR_W-1:0] ZERO = '0;
    int k;
    int n;
    cache_req_t item;

    rst = 1'b1;
    req_bus.valid   = 1'b0;
    req_bus.opcode  = OP_LOOKUP;
    req_bus.addr_hi = '0;
    req_bus.addr_lo = '0;
    req_bus.new_mtu = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.data    = '0;
    item_typed      = 1'b0;
    item_want       = '0;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;
    rsp_hold_pending = 1'b0;
    lifetime = DEFAULT_VALIDITY;
    for (k = 0; k < ENTRIES; k++) begin
      slot_live[k] = 1'b0;
      slot_hi[k]   = '0;
      slot_lo[k]   = '0;
      slot_mtu[k]  = '0;
      slot_ttl[k]  = '0;
    end

    // Address pool: random, plus near misses and the extremes
    for (k = 0; k < POOL; k++) begin
      pool_hi[k] = {$urandom, $urandom};
      pool_lo[k] = {$urandom, $urandom};
    end
    pool_hi[1] = pool_hi[0];
    pool_lo[5] = pool_lo[4];
    pool_hi[2] = ZERO;
    pool_lo[2] = ZERO;
    pool_hi[3] = ONES;
    pool_lo[3] = ONES;

    add_row(OP_LOOKUP, ZERO, ZERO, '0, 1'b1, '{mtu_value: '0, found: 1'b0, stored: 1'b0});
    add_row(OP_SET, ONES, ONES, '1, 1'b1, '{mtu_value: '0, found: 1'b0, stored: 1'b1});
    add_row(OP_LOOKUP, ONES, ONES, '0, 1'b1, '{mtu_value: '1, found: 1'b1, stored: 1'b0});
    add_row(OP_SET, ZERO, ZERO, '0, 1'b1, '{mtu_value: '0, found: 1'b0, stored: 1'b1});
    add_row(OP_LOOKUP, ZERO, ZERO, '1, 1'b1, '{mtu_value: '0, found: 1'b1, stored: 1'b0});
    add_row(OP_SET, ONES, ONES, 32'd1280, 1'b0, '0);
    add_row(OP_LOOKUP, ONES, ONES, '0, 1'b0, '0);
    add_row(OP_UNUSED, ONES, ONES, '1, 1'b0, '0);
    add_row(OP_TICK, ONES, ZERO, '1, 1'b0, '0);
    add_row(OP_LOOKUP, ONES, ZERO, '0, 1'b0, '0);
    // fill the remaining 14 slots
    for (k = 4; k < 18; k++) add_row(OP_SET, pool_hi[k], pool_lo[k], $urandom, 1'b0, '0);
    // table full: a new address is dropped
    add_row(OP_SET, pool_hi[18], pool_lo[18], 32'd1500, 1'b1,
            '{mtu_value: '0, found: 1'b0, stored: 1'b0});
    add_row(OP_LOOKUP, pool_hi[18], pool_lo[18], '0, 1'b0, '0);

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) send_req(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    wait_idle();

    // short lifetimes are ignored; then the shortest legal one
    write_lifetime('0);
    write_lifetime(MIN_VALIDITY);
    write_lifetime(MIN_VALIDITY + 1'b1);

    // Aging: mostly ticks, so entries set at the short lifetime run out
    for (n = 0; n < 400; n++) begin
      if (n % 50 == 0) begin
        src_idle_on  = $urandom_range(0, 3) != 0;
        sink_idle_on = $urandom_range(0, 3) != 0;
      end
      send_req(pool_request(OP_TICK), 1'b0, '0);
      k = $urandom_range(0, 7);
      if (k == 0) send_req(pool_request(OP_LOOKUP), 1'b0, '0);
      else if (k == 1) send_req(pool_request(OP_SET), 1'b0, '0);
    end
    wait_idle();

    write_lifetime(TICK_W'(450));
    run_random(70);
    wait_idle();

    write_lifetime('1);
    // Back-pressure: sink holds off while requests keep coming
    src_idle_on = 1'b0;
    rsp_hold_pending = 1'b1;
    for (n = 0; n < 40; n++) begin
      item = pool_request($urandom_range(0, 1) ? OP_SET : OP_LOOKUP);
      send_req(item, 1'b0, '0);
    end
    run_random(70);
    wait_idle();

    $display("Run covered %0d requests: %0d lookup hits, %0d misses, %0d sets stored,",
             request_count, hit_count, miss_count, stored_count);
    $display("%0d sets dropped on a full table, %0d entries expired, %0d lifetime writes.",
             dropped_count, expired_count, lifetime_writes);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
